>>> design/gdr_pkg.sv
// Shared constants, codes and types of the grid diffusion relaxation block.
package gdr_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 32;
  localparam int IDX_W     = 5;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int FRAC_BITS = 16;

  // Field and register widths
  localparam int DATA_W    = 32;
  localparam int COUPLE_W  = 24;
  localparam int RECIP_W   = 16;
  localparam int SWEEP_W   = 10;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [COUPLE_W-1:0] COUPLE_RST = COUPLE_W'(58982);
  localparam logic [RECIP_W-1:0]  RECIP_RST  = RECIP_W'(14247);
  localparam logic [SWEEP_W-1:0]  SWEEP_RST  = SWEEP_W'(300);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEPS   = 2'd2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Status codes
  localparam logic [CMD_W-1:0] STAT_WRITTEN = 2'd0;
  localparam logic [CMD_W-1:0] STAT_DONE    = 2'd1;
  localparam logic [CMD_W-1:0] STAT_DATA    = 2'd2;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR  = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd2;
  localparam logic [OP_W-1:0] OP_MLO  = 4'd3;
  localparam logic [OP_W-1:0] OP_MHI  = 4'd4;
  localparam logic [OP_W-1:0] OP_PRND = 4'd5;
  localparam logic [OP_W-1:0] OP_TSUM = 4'd6;
  localparam logic [OP_W-1:0] OP_RLO  = 4'd7;
  localparam logic [OP_W-1:0] OP_RHI  = 4'd8;
  localparam logic [OP_W-1:0] OP_QRND = 4'd9;

  // Controller to datapath commands
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] den_addr;
    logic              den_we;
    logic              den_wzero;
    logic [ADDR_W-1:0] src_addr;
    logic              src_we;
    logic              src_wzero;
    logic              nb_ok;
    logic              out_load;
    logic              out_rd;
  } dp_cmd_t;

endpackage

>>> design/grid_diffusion_relaxation.sv
// Top level: register file, stream ports, controller and datapath.
// Gauss-Seidel five-point diffusion solver on a 32 by 32 grid of signed
// Q16.16 cells. After reset the block zeroes both grids in a clearing pass
// and takes no command word meanwhile (register writes are taken). A source
// write is done as it is accepted; a cell read goes through a read state. A
// run updates every cell in each of sweep_count sweeps by a sequence of
// neighbor reads on the single-read density memory followed by the split
// multiplications. The result word waits in an output register; the next
// command is taken as that word leaves.
module grid_diffusion_relaxation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [47:0]                      s_axis_tdata,  // row, column, source_value
  input  logic [gdr_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gdr_pkg::DATA_W-1:0]       m_axis_tdata,  // density_value
  output logic [gdr_pkg::CMD_W-1:0]        m_axis_tuser,  // status
  input  logic                             cfg_we_i,
  input  logic [gdr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gdr_pkg::COUPLE_W-1:0]     cfg_data_i
);

  logic [gdr_pkg::COUPLE_W-1:0] coupling_q;
  logic [gdr_pkg::RECIP_W-1:0]  recip_q;
  logic [gdr_pkg::SWEEP_W-1:0]  sweeps_q;
  gdr_pkg::dp_cmd_t             dp_cmd;
  logic [gdr_pkg::ADDR_W-1:0]   in_cell;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q <= gdr_pkg::COUPLE_RST;
      recip_q    <= gdr_pkg::RECIP_RST;
      sweeps_q   <= gdr_pkg::SWEEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gdr_pkg::REG_COUPLING: coupling_q <= cfg_data_i;
        gdr_pkg::REG_RECIP:    recip_q    <= cfg_data_i[gdr_pkg::RECIP_W-1:0];
        gdr_pkg::REG_SWEEPS:   sweeps_q   <= cfg_data_i[gdr_pkg::SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell address is row-major: row in the upper bits
  assign in_cell = {s_axis_tdata[4:0], s_axis_tdata[9:5]};

  gdr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_cell_i     (in_cell),
    .sweep_count_i (sweeps_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (m_axis_tuser),
    .dp_o          (dp_cmd)
  );

  gdr_datapath u_datapath (
    .clk_i       (clk_i),
    .dp_i        (dp_cmd),
    .src_wdata_i (s_axis_tdata[41:10]),
    .coupling_i  (coupling_q),
    .recip_i     (recip_q),
    .out_value_o (m_axis_tdata)
  );

endmodule

>>> design/gdr_datapath.sv
// Datapath: grid memories and the fixed-point cell update arithmetic.
module gdr_datapath (
  input  logic                          clk_i,
  input  gdr_pkg::dp_cmd_t              dp_i,
  input  logic [gdr_pkg::DATA_W-1:0]    src_wdata_i,
  input  logic [gdr_pkg::COUPLE_W-1:0]  coupling_i,
  input  logic [gdr_pkg::RECIP_W-1:0]   recip_i,
  output logic [gdr_pkg::DATA_W-1:0]    out_value_o
);

  localparam int SUM_W  = 34;
  localparam int SLO_W  = 17;
  localparam int P_W    = 43;
  localparam int PF_W   = P_W + SLO_W - 1;
  localparam int T_W    = 44;
  localparam int TLO_W  = 22;
  localparam int R_W    = 40;
  localparam int QF_W   = 62;
  localparam int Q_W    = QF_W - gdr_pkg::FRAC_BITS;

  logic [gdr_pkg::DATA_W-1:0] den_mem [gdr_pkg::CELLS];
  logic [gdr_pkg::DATA_W-1:0] src_mem [gdr_pkg::CELLS];
  logic [gdr_pkg::DATA_W-1:0] den_rdata_q;
  logic [gdr_pkg::DATA_W-1:0] src_rdata_q;
  logic [gdr_pkg::DATA_W-1:0] den_wdata;
  logic [gdr_pkg::DATA_W-1:0] src_wdata;

  logic signed [SUM_W-1:0]    sum_q;
  logic signed [P_W-1:0]      plo_q, phi_q, pr_q;
  logic signed [T_W-1:0]      t_q;
  logic signed [R_W-1:0]      rlo_q, rhi_q;
  logic [gdr_pkg::DATA_W-1:0] q_q;
  logic [gdr_pkg::DATA_W-1:0] out_q;

  logic signed [SUM_W-1:0]    sum_d;
  logic signed [SLO_W:0]      sum_lo_s;
  logic signed [SUM_W-SLO_W-1:0] sum_hi_s;
  logic signed [gdr_pkg::COUPLE_W:0] coup_s;
  logic signed [gdr_pkg::RECIP_W:0]  rec_s;
  logic signed [P_W-1:0]      plo_w, phi_w, pr_w;
  logic signed [PF_W-1:0]     pfull;
  logic signed [T_W-1:0]      t_w;
  logic signed [TLO_W:0]      tlo_s;
  logic signed [T_W-TLO_W-1:0] thi_s;
  logic signed [R_W-1:0]      rlo_w, rhi_w;
  logic signed [QF_W-1:0]     qfull;
  logic signed [Q_W-1:0]      q_w;
  logic [gdr_pkg::DATA_W-1:0] q_sat;

  // Write data: zeros during the clearing pass
  assign den_wdata = dp_i.den_wzero ? '0 : q_q;
  assign src_wdata = dp_i.src_wzero ? '0 : src_wdata_i;

  // Grid memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (dp_i.den_we) begin
      den_mem[dp_i.den_addr] <= den_wdata;
    end
    den_rdata_q <= den_mem[dp_i.den_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dp_i.src_we) begin
      src_mem[dp_i.src_addr] <= src_wdata;
    end
    src_rdata_q <= src_mem[dp_i.src_addr];
  end

  // Neighbor sum, masked at the grid edge
  assign sum_d = sum_q + (dp_i.nb_ok ? SUM_W'($signed(den_rdata_q)) : '0);

  // Coupling product in two halves, then round
  assign sum_lo_s = $signed({1'b0, sum_q[SLO_W-1:0]});
  assign sum_hi_s = sum_q[SUM_W-1:SLO_W];
  assign coup_s   = $signed({1'b0, coupling_i});
  assign plo_w    = P_W'(sum_lo_s) * P_W'(coup_s);
  assign phi_w    = P_W'(sum_hi_s) * P_W'(coup_s);
  assign pfull    = (PF_W'(phi_q) <<< SLO_W) + PF_W'(plo_q)
                  + PF_W'(1 << (gdr_pkg::FRAC_BITS - 1));
  assign pr_w     = pfull[PF_W-1:gdr_pkg::FRAC_BITS];

  // Add the source term
  assign t_w = T_W'($signed(src_rdata_q)) + T_W'(pr_q);

  // Reciprocal product in two halves, then round and clamp
  assign tlo_s = $signed({1'b0, t_q[TLO_W-1:0]});
  assign thi_s = t_q[T_W-1:TLO_W];
  assign rec_s = $signed({1'b0, recip_i});
  assign rlo_w = R_W'(tlo_s) * R_W'(rec_s);
  assign rhi_w = R_W'(thi_s) * R_W'(rec_s);
  assign qfull = (QF_W'(rhi_q) <<< TLO_W) + QF_W'(rlo_q)
               + QF_W'(1 << (gdr_pkg::FRAC_BITS - 1));
  assign q_w   = qfull[QF_W-1:gdr_pkg::FRAC_BITS];

  always_comb begin
    if ((&q_w[Q_W-1:gdr_pkg::DATA_W-1]) || !(|q_w[Q_W-1:gdr_pkg::DATA_W-1])) begin
      q_sat = q_w[gdr_pkg::DATA_W-1:0];
    end else if (q_w[Q_W-1]) begin
      q_sat = {1'b1, {(gdr_pkg::DATA_W-1){1'b0}}};
    end else begin
      q_sat = {1'b0, {(gdr_pkg::DATA_W-1){1'b1}}};
    end
  end

  // Step the update arithmetic as the controller directs
  always_ff @(posedge clk_i) begin
    case (dp_i.op)
      gdr_pkg::OP_CLR:  sum_q <= '0;
      gdr_pkg::OP_ADD:  sum_q <= sum_d;
      gdr_pkg::OP_MLO:  plo_q <= plo_w;
      gdr_pkg::OP_MHI:  phi_q <= phi_w;
      gdr_pkg::OP_PRND: pr_q  <= pr_w;
      gdr_pkg::OP_TSUM: t_q   <= t_w;
      gdr_pkg::OP_RLO:  rlo_q <= rlo_w;
      gdr_pkg::OP_RHI:  rhi_q <= rhi_w;
      gdr_pkg::OP_QRND: q_q   <= q_sat;
      default: ;
    endcase
  end

  // Result word value
  always_ff @(posedge clk_i) begin
    if (dp_i.out_load) begin
      out_q <= dp_i.out_rd ? den_rdata_q : '0;
    end
  end

  assign out_value_o = out_q;

endmodule

>>> design/gdr_ctrl.sv
// Controller: clearing pass, command handling and the sweep sequencer.
module gdr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gdr_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [gdr_pkg::ADDR_W-1:0]    in_cell_i,
  input  logic [gdr_pkg::SWEEP_W-1:0]   sweep_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gdr_pkg::CMD_W-1:0]     out_status_o,
  output gdr_pkg::dp_cmd_t              dp_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;
  localparam logic [gdr_pkg::ADDR_W-1:0] LAST_CELL = gdr_pkg::ADDR_W'(gdr_pkg::CELLS - 1);
  localparam logic [gdr_pkg::ADDR_W-1:0] ROW_STEP  = gdr_pkg::ADDR_W'(gdr_pkg::GRID_SIZE);
  localparam logic [gdr_pkg::IDX_W-1:0]  LAST_IDX  = gdr_pkg::IDX_W'(gdr_pkg::GRID_SIZE - 1);

  logic [1:0]                     state_q, state_d;
  logic [gdr_pkg::ADDR_W-1:0]     cell_q, cell_d;
  logic [gdr_pkg::SWEEP_W-1:0]    sweep_q, sweep_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  logic [gdr_pkg::CMD_W-1:0]      status_q, status_d;

  logic                           accept;
  logic [gdr_pkg::IDX_W-1:0]      row, col;
  logic                           up_ok, down_ok, left_ok, right_ok;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign row      = cell_q[gdr_pkg::ADDR_W-1:gdr_pkg::IDX_W];
  assign col      = cell_q[gdr_pkg::IDX_W-1:0];
  assign up_ok    = (row != '0);
  assign down_ok  = (row != LAST_IDX);
  assign left_ok  = (col != '0);
  assign right_ok = (col != LAST_IDX);

  always_comb begin
    state_d     = state_q;
    cell_d      = cell_q;
    sweep_d     = sweep_q;
    step_d      = step_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dp_o           = '0;
    dp_o.op        = gdr_pkg::OP_IDLE;
    dp_o.den_addr  = in_cell_i;
    dp_o.src_addr  = in_cell_i;

    case (state_q)
      // Zero both grids, one cell a cycle
      ST_CLEAR: begin
        dp_o.den_addr  = cell_q;
        dp_o.src_addr  = cell_q;
        dp_o.den_we    = 1'b1;
        dp_o.src_we    = 1'b1;
        dp_o.den_wzero = 1'b1;
        dp_o.src_wzero = 1'b1;
        cell_d = cell_q + 1'b1;
        if (cell_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end

      // Take a command word
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            gdr_pkg::CMD_WRITE: begin
              dp_o.src_we   = 1'b1;
              dp_o.out_load = 1'b1;
              out_valid_d   = 1'b1;
              status_d      = gdr_pkg::STAT_WRITTEN;
            end
            gdr_pkg::CMD_RUN: begin
              if (sweep_count_i == '0) begin
                dp_o.out_load = 1'b1;
                out_valid_d   = 1'b1;
                status_d      = gdr_pkg::STAT_DONE;
              end else begin
                state_d = ST_RUN;
                cell_d  = '0;
                sweep_d = '0;
                step_d  = '0;
              end
            end
            gdr_pkg::CMD_READ: begin
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end

      // Deliver the density cell read last cycle
      ST_READ: begin
        dp_o.out_load = 1'b1;
        dp_o.out_rd   = 1'b1;
        out_valid_d   = 1'b1;
        status_d      = gdr_pkg::STAT_DATA;
        state_d       = ST_IDLE;
      end

      // Sequence one cell update, then advance cell and sweep
      ST_RUN: begin
        dp_o.src_addr = cell_q;
        dp_o.den_addr = cell_q;
        step_d        = step_q + 1'b1;
        case (step_q)
          4'd0: begin
            dp_o.op       = gdr_pkg::OP_CLR;
            dp_o.den_addr = cell_q - ROW_STEP;
          end
          4'd1: begin
            dp_o.op       = gdr_pkg::OP_ADD;
            dp_o.nb_ok    = up_ok;
            dp_o.den_addr = cell_q + ROW_STEP;
          end
          4'd2: begin
            dp_o.op       = gdr_pkg::OP_ADD;
            dp_o.nb_ok    = down_ok;
            dp_o.den_addr = cell_q - 1'b1;
          end
          4'd3: begin
            dp_o.op       = gdr_pkg::OP_ADD;
            dp_o.nb_ok    = left_ok;
            dp_o.den_addr = cell_q + 1'b1;
          end
          4'd4: begin
            dp_o.op    = gdr_pkg::OP_ADD;
            dp_o.nb_ok = right_ok;
          end
          4'd5:  dp_o.op = gdr_pkg::OP_MLO;
          4'd6:  dp_o.op = gdr_pkg::OP_MHI;
          4'd7:  dp_o.op = gdr_pkg::OP_PRND;
          4'd8:  dp_o.op = gdr_pkg::OP_TSUM;
          4'd9:  dp_o.op = gdr_pkg::OP_RLO;
          4'd10: dp_o.op = gdr_pkg::OP_RHI;
          4'd11: dp_o.op = gdr_pkg::OP_QRND;
          default: begin
            dp_o.den_we = 1'b1;
            step_d      = '0;
            cell_d      = cell_q + 1'b1;
            if (cell_q == LAST_CELL) begin
              sweep_d = sweep_q + 1'b1;
              if (sweep_q == sweep_count_i - 1'b1) begin
                state_d       = ST_IDLE;
                dp_o.out_load = 1'b1;
                out_valid_d   = 1'b1;
                status_d      = gdr_pkg::STAT_DONE;
              end
            end
          end
        endcase
        if (step_q > STEP_LAST) begin
          step_d = '0;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cell_q      <= '0;
      sweep_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= gdr_pkg::STAT_WRITTEN;
    end else begin
      state_q     <= state_d;
      cell_q      <= cell_d;
      sweep_q     <= sweep_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;

endmodule
